// File: hdl/button_debounce_key_repeat_assert.svh
// Assertion macros shared by the button debounce and key repeat block.
`ifndef BUTTON_DEBOUNCE_KEY_REPEAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_KEY_REPEAT_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define BDKR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define BDKR_ASSERT_NEVER(label, cond, msg) \
  `BDKR_ASSERT(label, !(cond), msg)
`else
`define BDKR_ASSERT(label, prop, msg)
`define BDKR_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// File: hdl/bdkr_pkg.sv
// Types and constants of the button debounce and key repeat block.
package bdkr_pkg;

  localparam int unsigned NumButtons = 4;
  localparam int unsigned CfgIdxW    = 3;

  // Action codes of an input item
  localparam logic ActService = 1'b0;
  localparam logic ActResync  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegDebounce      = 3'd0,
    RegInitDelay     = 3'd1,
    RegFirstInterval = 3'd2,
    RegSecondDelay   = 3'd3,
    RegSecondIntvl   = 3'd4
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [15:0] DebounceRst      = 16'd20;
  localparam logic [15:0] InitDelayRst     = 16'd400;
  localparam logic [15:0] FirstIntervalRst = 16'd120;
  localparam logic [15:0] SecondDelayRst   = 16'd1500;
  localparam logic [15:0] SecondIntvlRst   = 16'd50;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] initial_repeat_delay_ms;
    logic [15:0] first_repeat_interval_ms;
    logic [15:0] second_repeat_delay_ms;
    logic [15:0] second_repeat_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic                  action;
    logic [31:0]           now_ms;
    logic [NumButtons-1:0] pressed_levels;
    logic [NumButtons-1:0] pending_mask;
  } in_item_t;

  typedef struct packed {
    logic [NumButtons-1:0] stable_pressed;
    logic [NumButtons-1:0] press_events;
    logic [NumButtons-1:0] release_events;
  } out_item_t;

endpackage

// File: hdl/bdkr_cfg.sv
// Configuration register file of the button debounce and key repeat block.
module bdkr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [bdkr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  output bdkr_pkg::cfg_t                cfg_o
);

  bdkr_pkg::cfg_t cfg_d, cfg_q;

  // Decode the register index; writes beyond the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (bdkr_pkg::cfg_reg_e'(cfg_index_i))
        bdkr_pkg::RegDebounce:      cfg_d.debounce_ms               = cfg_data_i;
        bdkr_pkg::RegInitDelay:     cfg_d.initial_repeat_delay_ms   = cfg_data_i;
        bdkr_pkg::RegFirstInterval: cfg_d.first_repeat_interval_ms  = cfg_data_i;
        bdkr_pkg::RegSecondDelay:   cfg_d.second_repeat_delay_ms    = cfg_data_i;
        bdkr_pkg::RegSecondIntvl:   cfg_d.second_repeat_interval_ms = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms               <= bdkr_pkg::DebounceRst;
      cfg_q.initial_repeat_delay_ms   <= bdkr_pkg::InitDelayRst;
      cfg_q.first_repeat_interval_ms  <= bdkr_pkg::FirstIntervalRst;
      cfg_q.second_repeat_delay_ms    <= bdkr_pkg::SecondDelayRst;
      cfg_q.second_repeat_interval_ms <= bdkr_pkg::SecondIntvlRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/bdkr_lane.sv
// One button lane: debounce lockout, press/release detection and repeat timing.
module bdkr_lane (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           commit_i,
  input  logic           resync_i,
  input  logic [31:0]    now_i,
  input  logic           level_i,
  input  logic           pend_i,
  input  bdkr_pkg::cfg_t cfg_i,
  input  logic           all_held_i,
  output logic           level_o,
  output logic           press_o,
  output logic           release_o
);

  logic        dbc_d, dbc_q;
  logic [31:0] last_d, last_q;
  logic [31:0] hold_d, hold_q;
  logic [31:0] next_d, next_q;

  logic        flagged, lock_ok, chg;
  logic        dbc_1;
  logic [31:0] hold_1, next_1;
  logic [31:0] arm_time, held, rep_time;
  logic        rep;

  // Accept a flagged level change once the lockout window has passed
  assign flagged  = pend_i && (level_i != dbc_q);
  assign lock_ok  = (now_i - last_q) >= {16'd0, cfg_i.debounce_ms};
  assign chg      = flagged && lock_ok;
  assign arm_time = now_i + {16'd0, cfg_i.initial_repeat_delay_ms};

  // State after the change
  assign dbc_1  = chg ? level_i : dbc_q;
  assign hold_1 = chg ? (level_i ? now_i : 32'd0) : hold_q;
  assign next_1 = chg ? (level_i ? arm_time : 32'd0) : next_q;

  // Fire a repeat when armed and due and not every button is held, picking the rate from the hold time
  assign rep      = !all_held_i && dbc_1 && (next_1 != 32'd0) && (now_i >= next_1);
  assign held     = now_i - hold_1;
  assign rep_time = now_i + {16'd0, (held >= {16'd0, cfg_i.second_repeat_delay_ms})
                                    ? cfg_i.second_repeat_interval_ms
                                    : cfg_i.first_repeat_interval_ms};

  always_comb begin
    if (resync_i) begin
      dbc_d     = level_i;
      last_d    = 32'd0;
      hold_d    = level_i ? now_i : 32'd0;
      next_d    = level_i ? arm_time : 32'd0;
      press_o   = 1'b0;
      release_o = 1'b0;
    end else begin
      dbc_d     = dbc_1;
      last_d    = chg ? now_i : last_q;
      hold_d    = hold_1;
      next_d    = rep ? rep_time : next_1;
      press_o   = (chg && level_i) || rep;
      release_o = chg && !level_i;
    end
  end

  assign level_o = dbc_d;

  // Update the lane state when the item commits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbc_q  <= 1'b0;
      last_q <= 32'd0;
      hold_q <= 32'd0;
      next_q <= 32'd0;
    end else if (commit_i) begin
      dbc_q  <= dbc_d;
      last_q <= last_d;
      hold_q <= hold_d;
      next_q <= next_d;
    end
  end

endmodule

// File: hdl/button_debounce_key_repeat.sv
// Four-button debouncer with lockout window and two-rate key repeat. Each
// service item (time stamp, pin levels, changed mask) yields exactly one
// result with the debounced levels and the press/repeat and release events
// of that item. The block takes one item per clock cycle while the output is
// not stalled and delivers its result through the input register and then
// the result register; the rate rests on the per-button time registers being
// updated as each item commits, ready for the next item to read. A full
// result register under stall holds the input side as well. Configuration
// writes are always taken and must be issued only while the block is idle.
`include "button_debounce_key_repeat_assert.svh"

module button_debounce_key_repeat (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bdkr_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bdkr_pkg::out_item_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bdkr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                  cfg_data_i
);

  localparam int unsigned NB = bdkr_pkg::NumButtons;

  bdkr_pkg::cfg_t      cfg;
  bdkr_pkg::in_item_t  s1_item_q;
  bdkr_pkg::out_item_t out_item_d, out_item_q;
  logic                s1_valid_q, out_valid_q;
  logic                advance, commit, in_xfer, resync, all_held;
  logic [NB-1:0]       lvl_next, press, rel;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  bdkr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline flow: advance when the result register is free or drains
  assign advance    = !out_valid_q || !out_stall_i;
  assign commit     = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign resync     = (s1_item_q.action == bdkr_pkg::ActResync);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_data_i;
    end
  end

  // Per-button lanes
  for (genvar b = 0; b < NB; b++) begin : g_lane
    bdkr_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .commit_i   (commit),
      .resync_i   (resync),
      .now_i      (s1_item_q.now_ms),
      .level_i    (s1_item_q.pressed_levels[b]),
      .pend_i     (s1_item_q.pending_mask[b]),
      .cfg_i      (cfg),
      .all_held_i (all_held),
      .level_o    (lvl_next[b]),
      .press_o    (press[b]),
      .release_o  (rel[b])
    );
  end

  // Suppress repeats while every button is held
  assign all_held = &lvl_next;

  // Result register
  always_comb begin
    out_item_d.stable_pressed = lvl_next;
    out_item_d.press_events   = press;
    out_item_d.release_events = rel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  // Checks
  `BDKR_ASSERT_NEVER(a_press_release_excl,
    out_valid_o && ((out_data_o.press_events & out_data_o.release_events) != '0),
    "press and release on one button")
  `BDKR_ASSERT_NEVER(a_release_is_up,
    out_valid_o && ((out_data_o.release_events & out_data_o.stable_pressed) != '0),
    "release reported on a pressed button")
  `BDKR_ASSERT(a_stall_only_when_full, in_stall_o |-> (out_valid_o && out_stall_i),
    "input stalled with result register free")
  `BDKR_ASSERT(a_commit_yields_result, commit |=> out_valid_o,
    "committed item gave no result")

endmodule
